// ===== rtl/newton_square_root_macros.svh =====
// Assertion macros for the newton_square_root block.
// Active unless SYNTH is defined; expect clk and rst_n in the using scope.
`ifndef NEWTON_SQUARE_ROOT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_MACROS_SVH
`ifndef SYNTH
`define NSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSR_ASSERT_IMP(label, ante, cons, msg)
`define NSR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/nsr_pkg.sv =====
// Shared widths and defaults for the newton_square_root block.
// No dependencies.
package nsr_pkg;

    localparam int RADICAND_W            = 49;
    localparam int MAG_W                 = RADICAND_W - 1;
    localparam int ROOT_W                = 40;
    localparam int REM_W                 = ROOT_W + 1;
    localparam int QUOT_W                = 63;
    localparam int SQRT_W                = MAG_W / 2;
    localparam int CNT_W                 = 6;
    localparam int INPUT_FRAC_BITS_DEF   = 16;
    localparam int OUTPUT_FRAC_BITS_DEF  = 24;

    localparam logic [CNT_W-1:0] ITER_COUNT_RESET = CNT_W'(20);

endpackage

// ===== rtl/nsr_sub.sv =====
// Shared subtract/compare unit for the square root sequencer.
// Used by newton_square_root; no package dependencies.
module nsr_sub #(
    parameter int W = 41
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic [W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[W-1:0];
    assign ge   = ~wide[W];

endmodule

// ===== rtl/newton_square_root.sv =====
// Fixed-point square root, Babylonian steps on one shared subtract/compare unit.
// Negative, zero or exactly-one radicands go straight to DONE; otherwise an integer root seeds
//   the guess (if radicand > 1.0), and each step checks, divides and averages or saturates.
// One item in flight: the next transfer is taken in IDLE after the result is loaded;
//   a result not yet taken holds the sequencer in DONE.
// Reset clears control and sets iteration_count to 20. Depends on nsr_pkg, nsr_sub.
`include "newton_square_root_macros.svh"

module newton_square_root #(
    parameter int INPUT_FRAC_BITS  = nsr_pkg::INPUT_FRAC_BITS_DEF,
    parameter int OUTPUT_FRAC_BITS = nsr_pkg::OUTPUT_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [nsr_pkg::CNT_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [nsr_pkg::RADICAND_W-1:0] radicand,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [nsr_pkg::ROOT_W-1:0]          root,
    output logic                                negative_flag
);

    localparam int MAG_W  = nsr_pkg::MAG_W;
    localparam int ROOT_W = nsr_pkg::ROOT_W;
    localparam int REM_W  = nsr_pkg::REM_W;
    localparam int QUOT_W = nsr_pkg::QUOT_W;
    localparam int SQRT_W = nsr_pkg::SQRT_W;
    localparam int CNT_W  = nsr_pkg::CNT_W;

    localparam int SHIFT  = 2 * OUTPUT_FRAC_BITS - INPUT_FRAC_BITS;
    localparam int SHL    = (SHIFT > 0) ? SHIFT : 0;
    localparam int SHR    = (SHIFT < 0) ? -SHIFT : 0;
    localparam int NW     = (MAG_W + SHL > QUOT_W + 1) ? MAG_W + SHL : QUOT_W + 1;
    localparam int HW     = NW - QUOT_W;
    localparam int AW     = (HW > REM_W) ? HW : REM_W;
    localparam int SW     = (SQRT_W + OUTPUT_FRAC_BITS > ROOT_W) ?
                            SQRT_W + OUTPUT_FRAC_BITS : ROOT_W + 1;

    localparam logic [MAG_W-1:0]  ONE_IN   = MAG_W'(1) << INPUT_FRAC_BITS;
    localparam logic [ROOT_W-1:0] ONE_ROOT = ROOT_W'(1) << OUTPUT_FRAC_BITS;
    localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_SEED  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_AVG   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  iter_count_reg, iter_count_next;
    logic [CNT_W-1:0]  iter_left_reg, iter_left_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    logic [NW-1:0]     n_reg, n_next;
    logic [QUOT_W-1:0] nlo_reg, nlo_next;
    logic [MAG_W-1:0]  sq_val_reg, sq_val_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              neg_reg, neg_next;
    logic [ROOT_W-1:0] out_root_reg, out_root_next;
    logic              out_neg_reg, out_neg_next;

    logic [AW-1:0]     alu_a, alu_b, alu_diff;
    logic              alu_ge;

    logic              in_xfer, out_xfer;
    logic [MAG_W-1:0]  raw;
    logic [SQRT_W+2:0] sq_a;
    logic [SQRT_W+1:0] sq_b;
    logic [REM_W-1:0]  div_t;
    logic [SW-1:0]     seed_ext;
    logic [QUOT_W:0]   avg_sum;
    logic [QUOT_W-1:0] avg_half;

    nsr_sub #(
        .W (AW)
    ) u_sub (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign root      = out_root_reg;
    assign negative_flag = out_neg_reg;

    assign raw      = radicand[MAG_W-1:0];
    assign sq_a     = {rem_reg[SQRT_W:0], sq_val_reg[MAG_W-1 -: 2]};
    assign sq_b     = {q_reg[SQRT_W-1:0], 2'b01};
    assign div_t    = {rem_reg[ROOT_W-1:0], nlo_reg[QUOT_W-1]};
    assign seed_ext = SW'(q_reg[SQRT_W-1:0]) << OUTPUT_FRAC_BITS;
    assign avg_sum  = {1'b0, q_reg} + (QUOT_W + 1)'(root_reg);
    assign avg_half = avg_sum[QUOT_W:1];

    always_comb
    begin
        case (state_reg)
            ST_SQRT:
            begin
                alu_a = AW'(sq_a);
                alu_b = AW'(sq_b);
            end
            ST_CHECK:
            begin
                alu_a = AW'(n_reg[NW-1:QUOT_W]);
                alu_b = AW'(root_reg);
            end
            ST_DIV:
            begin
                alu_a = AW'(div_t);
                alu_b = AW'(root_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        iter_count_next = iter_count_reg;
        iter_left_next  = iter_left_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        n_next          = n_reg;
        nlo_next        = nlo_reg;
        sq_val_next     = sq_val_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        root_next       = root_reg;
        neg_next        = neg_reg;
        out_root_next   = out_root_reg;
        out_neg_next    = out_neg_reg;

        if (cfg_wr_en)
        begin
            iter_count_next = cfg_wr_data;
        end
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next      = (NW'(raw) << SHL) >> SHR;
                    neg_next    = radicand[MAG_W];
                    rem_next    = '0;
                    q_next      = '0;
                    step_next   = '0;
                    sq_val_next = raw >> INPUT_FRAC_BITS;
                    if (radicand[MAG_W])
                    begin
                        root_next  = '0;
                        state_next = ST_DONE;
                    end
                    else if (raw == '0)
                    begin
                        root_next  = '0;
                        state_next = ST_DONE;
                    end
                    else if (raw == ONE_IN)
                    begin
                        root_next  = ONE_ROOT;
                        state_next = ST_DONE;
                    end
                    else if (raw < ONE_IN)
                    begin
                        q_next     = QUOT_W'(1);
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                sq_val_next = sq_val_reg << 2;
                if (alu_ge)
                begin
                    rem_next = alu_diff[REM_W-1:0];
                    q_next   = QUOT_W'({q_reg[SQRT_W-2:0], 1'b1});
                end
                else
                begin
                    rem_next = REM_W'(sq_a);
                    q_next   = QUOT_W'({q_reg[SQRT_W-2:0], 1'b0});
                end
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(SQRT_W - 1))
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                root_next = (|seed_ext[SW-1:ROOT_W]) ? ROOT_MAX : seed_ext[ROOT_W-1:0];
                iter_left_next = iter_count_reg;
                state_next = (iter_count_reg == '0) ? ST_DONE : ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((root_reg == '0) || alu_ge)
                begin
                    root_next      = ROOT_MAX;
                    iter_left_next = iter_left_reg - CNT_W'(1);
                    state_next     = (iter_left_reg == CNT_W'(1)) ? ST_DONE : ST_CHECK;
                end
                else
                begin
                    rem_next   = REM_W'(n_reg[NW-1:QUOT_W]);
                    nlo_next   = n_reg[QUOT_W-1:0];
                    q_next     = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                nlo_next = nlo_reg << 1;
                if (alu_ge)
                begin
                    rem_next = alu_diff[REM_W-1:0];
                    q_next   = {q_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_t;
                    q_next   = {q_reg[QUOT_W-2:0], 1'b0};
                end
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(QUOT_W - 1))
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                root_next = (|avg_half[QUOT_W-1:ROOT_W]) ? ROOT_MAX : avg_half[ROOT_W-1:0];
                iter_left_next = iter_left_reg - CNT_W'(1);
                state_next     = (iter_left_reg == CNT_W'(1)) ? ST_DONE : ST_CHECK;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_root_next  = neg_reg ? '0 : root_reg;
                    out_neg_next   = neg_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iter_count_reg <= nsr_pkg::ITER_COUNT_RESET;
            iter_left_reg  <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iter_count_reg <= iter_count_next;
            iter_left_reg  <= iter_left_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        nlo_reg      <= nlo_next;
        sq_val_reg   <= sq_val_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        root_reg     <= root_next;
        neg_reg      <= neg_next;
        out_root_reg <= out_root_next;
        out_neg_reg  <= out_neg_next;
    end

    `NSR_ASSERT_IMP(a_neg_root_zero, out_valid_reg && out_neg_reg, out_root_reg == '0, "neg root")
    `NSR_ASSERT_IMP(a_div_rem_bound, state_reg == ST_DIV, rem_reg < {1'b0, root_reg}, "div rem")
    `NSR_ASSERT_IMP(a_sqrt_step_range, state_reg == ST_SQRT, step_reg < CNT_W'(SQRT_W), "step")
    `NSR_ASSERT_NXT(a_accept_busy, in_xfer, state_reg != ST_IDLE, "idle after transfer")

endmodule
